@@ rtl/pnfb_pkg.sv @@
// Shared request codes, field widths and nibble helpers for the packed nibble frame store.
`default_nettype none

package pnfb_pkg;

   // Request kinds carried on the input tuser.
   typedef enum logic [1:0] {
      REQ_CLEAR  = 2'd0,
      REQ_SET    = 2'd1,
      REQ_GET    = 2'd2,
      REQ_ROTATE = 2'd3
   } req_kind_type;

   localparam int X_W     = 10;
   localparam int Y_W     = 9;
   localparam int COLOR_W = 4;
   localparam int SIDX_W  = 18;
   // Wide enough for any linear byte address or stream index the fields can form.
   localparam int LIN_W   = 19;

   localparam logic [7:0] HI_NIBBLE = 8'hF0;
   localparam logic [7:0] LO_NIBBLE = 8'h0F;

   function automatic logic [7:0] swap_nibbles(input logic [7:0] b);
      swap_nibbles = ((b & LO_NIBBLE) << 4) | ((b & HI_NIBBLE) >> 4);
   endfunction

endpackage

`default_nettype wire

@@ rtl/packed_nibble_framebuffer.sv @@
// Top level of the packed 4-bit frame store with set, get, clear and rotated readout.
//
//   Channel   Ports            Beat contents (lowest bit first)
//   request   req_t*           tdata: pixel_x, pixel_y, pixel_color, stream_index; tuser: kind
//   response  rsp_t*           tdata: read_color, read_byte; tuser: status
//   config    csr_wr_*         white_code, taken in any cycle the enable is high
//
// Set, get and readout: the accept cycle issues the memory read and the access state
// does the modify, the write back and loads the response register, once it is free.
// A clear is accepted, then the sweep writes one byte per cycle over the whole store
// with the clear colour in both nibbles, and the access state loads the response.
// After reset the same sweep zeroes the store with req_tready low.
// A new request is accepted while a response still waits; a stalled response holds
// the next request in the access state until the response register frees up.
`default_nettype none

module packed_nibble_framebuffer #(
   parameter int WIDTH  = 800,
   parameter int HEIGHT = 480
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // pixel_x[9:0], pixel_y[18:10], pixel_color[22:19], stream_index[40:23], zero fill
   input  wire logic [47:0] req_tdata,
   // kind[1:0]
   input  wire logic [1:0]  req_tuser,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // read_color[3:0], read_byte[11:4], zero fill
   output logic [15:0]      rsp_tdata,
   // status[0]
   output logic [0:0]       rsp_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic        csr_wr_en,
   input  wire logic [3:0]  csr_wr_data
);

   localparam int ROW_BYTES = (WIDTH + 1) / 2;
   localparam int FB_SIZE   = ROW_BYTES * HEIGHT;
   localparam int ADDR_W    = (FB_SIZE > 1) ? $clog2(FB_SIZE) : 1;
   localparam int LIN_W     = pnfb_pkg::LIN_W;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_ACCESS = 3'b010,
      ST_SWEEP  = 3'b100
   } state_type;

   // Input fields.
   logic [pnfb_pkg::X_W-1:0]     pixel_x;
   logic [pnfb_pkg::Y_W-1:0]     pixel_y;
   logic [pnfb_pkg::COLOR_W-1:0] pixel_color;
   logic [pnfb_pkg::SIDX_W-1:0]  stream_index;
   pnfb_pkg::req_kind_type       req_kind;

   assign pixel_x      = req_tdata[9:0];
   assign pixel_y      = req_tdata[18:10];
   assign pixel_color  = req_tdata[22:19];
   assign stream_index = req_tdata[40:23];
   assign req_kind     = pnfb_pkg::req_kind_type'(req_tuser);

   state_type              state_ff, state_in;
   pnfb_pkg::req_kind_type kind_ff, kind_in;
   logic                   oor_ff, oor_in;
   logic                   xodd_ff, xodd_in;
   logic [3:0]             color_ff, color_in;
   logic [ADDR_W-1:0]      addr_ff, addr_in;
   logic [ADDR_W-1:0]      sweep_cnt_ff, sweep_cnt_in;
   logic [7:0]             fill_ff, fill_in;
   logic                   report_ff, report_in;
   logic [3:0]             white_ff, white_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [3:0]             rsp_color_ff, rsp_color_in;
   logic [7:0]             rsp_byte_ff, rsp_byte_in;
   logic                   rsp_status_ff, rsp_status_in;
   logic [7:0]             rd_data_ff;

   logic [7:0]             pixel_store [FB_SIZE];

   logic                   req_fire;
   logic                   coord_ok;
   logic                   sidx_ok;
   logic [LIN_W-1:0]       pix_lin;
   logic [LIN_W-1:0]       rot_lin;
   logic                   mem_re;
   logic [ADDR_W-1:0]      mem_raddr;
   logic                   mem_we;
   logic [ADDR_W-1:0]      mem_waddr;
   logic [7:0]             mem_wdata;
   logic                   rsp_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   assign coord_ok = ({1'b0, pixel_x} < 11'(WIDTH)) && ({1'b0, pixel_y} < 10'(HEIGHT));
   assign sidx_ok  = ({1'b0, stream_index} < LIN_W'(FB_SIZE));
   assign pix_lin  = LIN_W'(pixel_y) * LIN_W'(ROW_BYTES) + LIN_W'(pixel_x[9:1]);
   assign rot_lin  = LIN_W'(FB_SIZE - 1) - LIN_W'(stream_index);

   // The read for the whole request is issued in the accept cycle.
   always_comb begin
      mem_re    = 1'b0;
      mem_raddr = pix_lin[ADDR_W-1:0];
      oor_in    = 1'b0;
      unique case (req_kind) inside
         pnfb_pkg::REQ_SET, pnfb_pkg::REQ_GET: begin
            oor_in = !coord_ok;
            mem_re = req_fire && coord_ok;
         end
         pnfb_pkg::REQ_ROTATE: begin
            oor_in    = !sidx_ok;
            mem_re    = req_fire && sidx_ok;
            mem_raddr = rot_lin[ADDR_W-1:0];
         end
         default: begin
            oor_in = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      xodd_in       = xodd_ff;
      color_in      = color_ff;
      addr_in       = addr_ff;
      sweep_cnt_in  = sweep_cnt_ff;
      fill_in       = fill_ff;
      report_in     = report_ff;
      white_in      = csr_wr_en ? csr_wr_data : white_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_color_in  = rsp_color_ff;
      rsp_byte_in   = rsp_byte_ff;
      rsp_status_in = rsp_status_ff;
      mem_we        = 1'b0;
      mem_waddr     = addr_ff;
      mem_wdata     = fill_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               kind_in  = req_kind;
               xodd_in  = pixel_x[0];
               color_in = pixel_color;
               addr_in  = mem_raddr;
               if (req_kind == pnfb_pkg::REQ_CLEAR) begin
                  state_in     = ST_SWEEP;
                  sweep_cnt_in = '0;
                  fill_in      = {pixel_color, pixel_color};
                  report_in    = 1'b1;
               end else begin
                  state_in = ST_ACCESS;
               end
            end
         end
         ST_ACCESS: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_color_in  = '0;
               rsp_byte_in   = '0;
               rsp_status_in = oor_ff;
               state_in      = ST_IDLE;
               unique case (kind_ff)
                  pnfb_pkg::REQ_SET: begin
                     mem_we    = !oor_ff;
                     mem_wdata = xodd_ff ? {rd_data_ff[7:4], color_ff}
                                         : {color_ff, rd_data_ff[3:0]};
                  end
                  pnfb_pkg::REQ_GET: begin
                     if (oor_ff) begin
                        rsp_color_in = white_ff;
                     end else begin
                        rsp_color_in = xodd_ff ? rd_data_ff[3:0] : rd_data_ff[7:4];
                     end
                  end
                  pnfb_pkg::REQ_ROTATE: begin
                     rsp_byte_in = oor_ff ? 8'h00 : pnfb_pkg::swap_nibbles(rd_data_ff);
                  end
                  default: begin
                     rsp_status_in = 1'b0;
                  end
               endcase
            end
         end
         ST_SWEEP: begin
            mem_we    = 1'b1;
            mem_waddr = sweep_cnt_ff;
            mem_wdata = fill_ff;
            if (sweep_cnt_ff == ADDR_W'(FB_SIZE - 1)) begin
               state_in = report_ff ? ST_ACCESS : ST_IDLE;
            end else begin
               sweep_cnt_in = sweep_cnt_ff + ADDR_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         sweep_cnt_ff <= '0;
         fill_ff      <= '0;
         report_ff    <= 1'b0;
         white_ff     <= 4'd1;
         rsp_valid_ff <= 1'b0;
         kind_ff      <= pnfb_pkg::REQ_CLEAR;
      end else begin
         state_ff     <= state_in;
         sweep_cnt_ff <= sweep_cnt_in;
         fill_ff      <= fill_in;
         report_ff    <= report_in;
         white_ff     <= white_in;
         rsp_valid_ff <= rsp_valid_in;
         kind_ff      <= kind_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         oor_ff <= oor_in;
      end
      xodd_ff       <= xodd_in;
      color_ff      <= color_in;
      addr_ff       <= addr_in;
      rsp_color_ff  <= rsp_color_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_status_ff <= rsp_status_in;
   end

   // Frame store: one write port, one read port with registered data.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         pixel_store[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= pixel_store[mem_raddr];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'h0, rsp_byte_ff, rsp_color_ff};
   assign rsp_tuser  = rsp_status_ff;

   a_clear_starts_sweep: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_kind == pnfb_pkg::REQ_CLEAR) |=> (state_ff == ST_SWEEP))
      else $error("clear request did not start the sweep");

   a_access_follows_accept: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_kind != pnfb_pkg::REQ_CLEAR) |=> (state_ff == ST_ACCESS))
      else $error("pixel request did not move to the access cycle");

   a_rsp_from_access: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_ACCESS))
      else $error("response loaded outside the access cycle");

   a_sweep_in_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP) |-> (sweep_cnt_ff <= ADDR_W'(FB_SIZE - 1)))
      else $error("sweep address ran past the store");

   a_no_overlap_write_read: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> !mem_re)
      else $error("store read and write in the same cycle");

endmodule

`default_nettype wire
